@@ design/fsnf_pkg.sv @@
// Shared types, constants and the control store for the format string number formatter.
// Holds the microcode words, dispatch map and character codes; depends on nothing.
`default_nettype none

package fsnf_pkg;

    // Field widths of the stream items
    localparam int CHAR_W         = 8;
    localparam int ARG_W          = 32;
    localparam int IN_DATA_W      = 40;
    localparam int VALUE_BITS_DEF = 32;

    // Digit buffer: up to nine positions per conversion
    localparam int DIGITS_MAX = 9;
    localparam int CNT_W      = $clog2(DIGITS_MAX + 1);
    localparam int IDX_W      = $clog2(DIGITS_MAX);

    localparam logic [3:0]        WIDTH_RESET    = 4'd8;
    localparam logic [7:0]        ASCII_ZERO     = 8'h30;
    localparam logic [7:0]        ASCII_ALPHA_OFS = 8'h37;
    localparam logic [3:0]        DEC_BASE       = 4'd10;
    // floor(v / 10) == (v * DIV10_MAGIC) >> DIV10_SHIFT for any 32-bit v
    localparam logic [ARG_W-1:0]  DIV10_MAGIC    = 32'hCCCC_CCCD;
    localparam int                DIV10_SHIFT    = 35;

    // Character codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_C   = 8'h63;
    localparam logic [7:0] CH_LOW_D   = 8'h64;
    localparam logic [7:0] CH_LOW_X   = 8'h78;
    localparam logic [7:0] CH_UP_X    = 8'h58;

    typedef logic [3:0] t_addr;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_RESET,
        OP_SET_SPEC,
        OP_SET_ZF,
        OP_SET_WIDTH,
        OP_END_SPEC,
        OP_START_HEX,
        OP_START_DEC,
        OP_GEN,
        OP_EMITD
    } t_op;

    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_CHAR,
        SRC_ARG,
        SRC_TERM,
        SRC_DIGIT
    } t_src;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_WAIT_IN,
        JMP_DISPATCH,
        JMP_LOOP
    } t_jmp;

    typedef enum logic [3:0] {
        CLS_TERM,
        CLS_ECHO,
        CLS_OPEN,
        CLS_ZF,
        CLS_WIDTH,
        CLS_UNK,
        CLS_CHR,
        CLS_HEX,
        CLS_DEC
    } t_cls;

    typedef struct packed {
        logic  accept;
        t_op   op;
        t_src  src;
        t_jmp  jmp;
        t_addr target;
    } t_uword;

    typedef struct packed {
        logic in_acc;
        logic stall;
        logic more;
        t_cls cls;
    } t_stat;

    // Control store addresses
    localparam t_addr A_FETCH = 4'd0;
    localparam t_addr A_DISP  = 4'd1;
    localparam t_addr A_TERM  = 4'd2;
    localparam t_addr A_ECHO  = 4'd3;
    localparam t_addr A_OPEN  = 4'd4;
    localparam t_addr A_ZF    = 4'd5;
    localparam t_addr A_WIDTH = 4'd6;
    localparam t_addr A_ENDS  = 4'd7;
    localparam t_addr A_CHR   = 4'd8;
    localparam t_addr A_HEX   = 4'd9;
    localparam t_addr A_DEC   = 4'd10;
    localparam t_addr A_GEN   = 4'd11;
    localparam t_addr A_EMIT  = 4'd12;

    function automatic t_uword ucode(input t_addr addr);
        t_uword uw;
        uw = '{accept: 1'b0, op: OP_NOP, src: SRC_NONE, jmp: JMP_GOTO, target: A_FETCH};
        unique case (addr)
            A_FETCH: begin
                uw.accept = 1'b1;
                uw.op     = OP_LOAD;
                uw.jmp    = JMP_WAIT_IN;
            end
            A_DISP:  uw.jmp = JMP_DISPATCH;
            A_TERM: begin
                uw.op  = OP_RESET;
                uw.src = SRC_TERM;
            end
            A_ECHO:  uw.src = SRC_CHAR;
            A_OPEN:  uw.op  = OP_SET_SPEC;
            A_ZF:    uw.op  = OP_SET_ZF;
            A_WIDTH: uw.op  = OP_SET_WIDTH;
            A_ENDS:  uw.op  = OP_END_SPEC;
            A_CHR: begin
                uw.src    = SRC_ARG;
                uw.target = A_ENDS;
            end
            A_HEX: begin
                uw.op     = OP_START_HEX;
                uw.target = A_GEN;
            end
            A_DEC: begin
                uw.op     = OP_START_DEC;
                uw.target = A_GEN;
            end
            A_GEN: begin
                uw.op     = OP_GEN;
                uw.jmp    = JMP_LOOP;
                uw.target = A_EMIT;
            end
            A_EMIT: begin
                uw.op     = OP_EMITD;
                uw.src    = SRC_DIGIT;
                uw.jmp    = JMP_LOOP;
                uw.target = A_ENDS;
            end
            default: uw.target = A_FETCH;
        endcase
        return uw;
    endfunction

    function automatic t_addr dispatch(input t_cls cls);
        t_addr a;
        unique case (cls)
            CLS_TERM:  a = A_TERM;
            CLS_ECHO:  a = A_ECHO;
            CLS_OPEN:  a = A_OPEN;
            CLS_ZF:    a = A_ZF;
            CLS_WIDTH: a = A_WIDTH;
            CLS_CHR:   a = A_CHR;
            CLS_HEX:   a = A_HEX;
            CLS_DEC:   a = A_DEC;
            default:   a = A_ENDS;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

@@ design/fsnf_seq.sv @@
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on fsnf_pkg for the control word, status and dispatch map.
`default_nettype none

module fsnf_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire fsnf_pkg::t_stat i_stat,
    output fsnf_pkg::t_uword     o_uw
);

    fsnf_pkg::t_addr  r_pc;
    fsnf_pkg::t_addr  n_pc;
    fsnf_pkg::t_uword w_uw;

    assign w_uw = fsnf_pkg::ucode(r_pc);
    assign o_uw = w_uw;

    always_comb begin
        n_pc = r_pc;
        if (!i_stat.stall) begin
            unique case (w_uw.jmp)
                fsnf_pkg::JMP_NEXT:     n_pc = r_pc + 4'd1;
                fsnf_pkg::JMP_GOTO:     n_pc = w_uw.target;
                fsnf_pkg::JMP_WAIT_IN:  n_pc = i_stat.in_acc ? r_pc + 4'd1 : r_pc;
                fsnf_pkg::JMP_DISPATCH: n_pc = fsnf_pkg::dispatch(i_stat.cls);
                fsnf_pkg::JMP_LOOP:     n_pc = i_stat.more ? r_pc : w_uw.target;
                default:                n_pc = fsnf_pkg::A_FETCH;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= fsnf_pkg::A_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

@@ design/fsnf_dp.sv @@
// Datapath: format state, value register, digit generator, digit buffer, output register.
// Driven by control words from fsnf_seq; depends on fsnf_pkg.
`default_nettype none

module fsnf_dp #(
    parameter int VALUE_BITS = fsnf_pkg::VALUE_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire fsnf_pkg::t_uword               i_uw,
    input  wire logic                           i_s_tvalid,
    input  wire logic [fsnf_pkg::IN_DATA_W-1:0] i_s_tdata,
    input  wire logic                           i_m_tready,
    output fsnf_pkg::t_stat                     o_stat,
    output logic                                o_m_tvalid,
    output logic [fsnf_pkg::CHAR_W-1:0]         o_m_tdata,
    output logic                                o_m_tlast
);

    localparam int VW = (VALUE_BITS < fsnf_pkg::ARG_W) ? VALUE_BITS : fsnf_pkg::ARG_W;
    localparam int QW = 2 * fsnf_pkg::ARG_W - fsnf_pkg::DIV10_SHIFT;

    // Format state
    logic                         r_in_spec;
    logic [3:0]                   r_width;
    logic                         r_zf;
    // Per-item working registers
    logic [fsnf_pkg::CHAR_W-1:0]  r_char;
    logic [VW-1:0]                r_val;
    logic                         r_hex;
    logic                         r_started;
    logic [fsnf_pkg::CNT_W-1:0]   r_cnt;
    logic [3:0]                   r_dig [fsnf_pkg::DIGITS_MAX];
    // Output register
    logic                         r_o_valid;
    logic [fsnf_pkg::CHAR_W-1:0]  r_o_char;
    logic                         r_o_last;

    logic                         w_in_acc;
    fsnf_pkg::t_cls               w_cls;
    logic [fsnf_pkg::ARG_W-1:0]   w_opnd;
    logic [2*fsnf_pkg::ARG_W-1:0] w_prod;
    logic [QW-1:0]                w_quot;
    logic [fsnf_pkg::ARG_W-1:0]   w_q10;
    logic [fsnf_pkg::ARG_W-1:0]   w_rem;
    logic [3:0]                   w_gen_dig;
    logic [VW-1:0]                w_gen_val;
    logic [fsnf_pkg::CNT_W-1:0]   w_pos_cnt;
    logic [fsnf_pkg::IDX_W-1:0]   w_pos;
    logic [3:0]                   w_dig;
    logic                         w_pos_zero;
    logic                         w_dig_shown;
    logic                         w_emit;
    logic                         w_stall;
    logic [fsnf_pkg::CHAR_W-1:0]  w_emit_char;
    logic                         w_emit_last;
    logic                         w_more;

    assign w_in_acc = i_uw.accept && i_s_tvalid;

    // Classify the held character against the conversion state
    always_comb begin
        if (r_char == fsnf_pkg::CH_NUL) begin
            w_cls = fsnf_pkg::CLS_TERM;
        end else if (!r_in_spec) begin
            w_cls = (r_char == fsnf_pkg::CH_PERCENT) ? fsnf_pkg::CLS_OPEN : fsnf_pkg::CLS_ECHO;
        end else if (r_char == fsnf_pkg::CH_ZERO) begin
            w_cls = fsnf_pkg::CLS_ZF;
        end else if (r_char >= fsnf_pkg::CH_ONE && r_char <= fsnf_pkg::CH_NINE) begin
            w_cls = fsnf_pkg::CLS_WIDTH;
        end else if (r_char == fsnf_pkg::CH_LOW_C) begin
            w_cls = fsnf_pkg::CLS_CHR;
        end else if (r_char == fsnf_pkg::CH_LOW_X || r_char == fsnf_pkg::CH_UP_X) begin
            w_cls = fsnf_pkg::CLS_HEX;
        end else if (r_char == fsnf_pkg::CH_LOW_D) begin
            w_cls = fsnf_pkg::CLS_DEC;
        end else begin
            w_cls = fsnf_pkg::CLS_UNK;
        end
    end

    // Digit generator: least significant digit first; decimal divides by ten via reciprocal, hex shifts by four
    assign w_opnd    = fsnf_pkg::ARG_W'(r_val);
    assign w_prod    = (2*fsnf_pkg::ARG_W)'(w_opnd) * (2*fsnf_pkg::ARG_W)'(fsnf_pkg::DIV10_MAGIC);
    assign w_quot    = w_prod[2*fsnf_pkg::ARG_W-1:fsnf_pkg::DIV10_SHIFT];
    assign w_q10     = fsnf_pkg::ARG_W'({w_quot, 3'b000}) + fsnf_pkg::ARG_W'({w_quot, 1'b0});
    assign w_rem     = w_opnd - w_q10;
    assign w_gen_dig = r_hex ? r_val[3:0] : w_rem[3:0];
    assign w_gen_val = r_hex ? (r_val >> 4) : VW'(w_quot);

    // Emit side walks the buffer from the top position down
    assign w_pos_cnt   = r_cnt - fsnf_pkg::CNT_W'(1);
    assign w_pos       = w_pos_cnt[fsnf_pkg::IDX_W-1:0];
    assign w_dig       = r_dig[w_pos];
    assign w_pos_zero  = (w_pos_cnt == '0);
    assign w_dig_shown = (w_dig != 4'd0) || r_started || w_pos_zero;

    always_comb begin
        w_emit      = 1'b0;
        w_emit_char = '0;
        w_emit_last = 1'b1;
        case (i_uw.src)
            fsnf_pkg::SRC_CHAR: begin
                w_emit      = 1'b1;
                w_emit_char = r_char;
            end
            fsnf_pkg::SRC_ARG: begin
                w_emit      = 1'b1;
                w_emit_char = r_val[fsnf_pkg::CHAR_W-1:0];
            end
            fsnf_pkg::SRC_TERM: begin
                w_emit      = 1'b1;
                w_emit_char = fsnf_pkg::CH_NUL;
            end
            fsnf_pkg::SRC_DIGIT: begin
                w_emit      = w_dig_shown;
                w_emit_char = (w_dig < fsnf_pkg::DEC_BASE)
                            ? fsnf_pkg::ASCII_ZERO + 8'(w_dig)
                            : fsnf_pkg::ASCII_ALPHA_OFS + 8'(w_dig);
                w_emit_last = w_pos_zero;
            end
            default: w_emit = 1'b0;
        endcase
    end

    // Hold the whole step while it emits and the output register is full and not taken
    assign w_stall = w_emit && r_o_valid && !i_m_tready;

    assign w_more = (i_uw.op == fsnf_pkg::OP_GEN)
                  ? (r_cnt != fsnf_pkg::CNT_W'(r_width - 4'd1))
                  : !w_pos_zero;

    assign o_stat = '{in_acc: w_in_acc, stall: w_stall, more: w_more, cls: w_cls};

    // Control state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_spec <= 1'b0;
            r_width   <= fsnf_pkg::WIDTH_RESET;
            r_zf      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_emit && !w_stall) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
            if (!w_stall) begin
                case (i_uw.op)
                    fsnf_pkg::OP_RESET: begin
                        r_in_spec <= 1'b0;
                        r_width   <= fsnf_pkg::WIDTH_RESET;
                        r_zf      <= 1'b0;
                    end
                    fsnf_pkg::OP_SET_SPEC:  r_in_spec <= 1'b1;
                    fsnf_pkg::OP_SET_ZF:    r_zf      <= 1'b1;
                    fsnf_pkg::OP_SET_WIDTH: r_width   <= r_char[3:0];
                    fsnf_pkg::OP_END_SPEC: begin
                        r_in_spec <= 1'b0;
                        r_zf      <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_emit && !w_stall) begin
            r_o_char <= w_emit_char;
            r_o_last <= w_emit_last;
        end
        if (!w_stall) begin
            case (i_uw.op)
                fsnf_pkg::OP_LOAD: begin
                    if (w_in_acc) begin
                        r_char <= i_s_tdata[fsnf_pkg::CHAR_W-1:0];
                        r_val  <= i_s_tdata[fsnf_pkg::CHAR_W +: VW];
                    end
                end
                fsnf_pkg::OP_START_HEX, fsnf_pkg::OP_START_DEC: begin
                    r_hex     <= (i_uw.op == fsnf_pkg::OP_START_HEX);
                    r_cnt     <= '0;
                    r_started <= r_zf;
                end
                fsnf_pkg::OP_GEN: begin
                    r_dig[r_cnt[fsnf_pkg::IDX_W-1:0]] <= w_gen_dig;
                    r_val <= w_gen_val;
                    r_cnt <= r_cnt + fsnf_pkg::CNT_W'(1);
                end
                fsnf_pkg::OP_EMITD: begin
                    r_cnt <= w_pos_cnt;
                    if (w_dig_shown) begin
                        r_started <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_char;
    assign o_m_tlast  = r_o_last;

endmodule

`default_nettype wire

@@ design/format_string_number_formatter_core.sv @@
// Format string number formatter: printf style integer and character conversions.
// Slave stream: one format byte with its argument per transaction.
//   i_s_tdata[7:0] holds the format byte (zero ends the string), [39:8] the argument.
// Master stream: o_m_tdata[7:0] carries one output byte; o_m_tlast marks the final
//   byte produced for an input byte. Bytes that open or tune a conversion produce none.
// Operation: a small control program steps a shared datapath.
//   Plain bytes, flags and width digits pass fetch, dispatch and an action step; %c
//   adds the end-of-conversion step. %d and %x first build W digits for width W (divide
//   by ten for %d, shift by four for %x), then send them top first.
//   A new input byte is taken only in the fetch step of the program.
// Reset (synchronous, active low) restores width 8, no zero fill, outside a conversion.
// Receiver stall: the single output register holds its byte; the program halts on the
//   step that wants to emit the next byte and resumes when the register drains.
// Depends on fsnf_pkg, fsnf_seq and fsnf_dp.
`default_nettype none

module format_string_number_formatter_core #(
    parameter int VALUE_BITS = fsnf_pkg::VALUE_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [fsnf_pkg::IN_DATA_W-1:0] i_s_tdata,   // fmt_char[7:0], arg_value[39:8]
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [fsnf_pkg::CHAR_W-1:0]         o_m_tdata,   // out_char[7:0]
    output logic                                o_m_tlast
);

    fsnf_pkg::t_uword w_uw;
    fsnf_pkg::t_stat  w_stat;

    fsnf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_uw    (w_uw)
    );

    fsnf_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_uw       (w_uw),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_stat     (w_stat),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    assign o_s_tready = w_uw.accept;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking bench for format_string_number_formatter_core: streams format bytes with
// arguments, predicts the formatted output bytes and checks every output transaction.
// Depends on fsnf_pkg and the formatter RTL.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int            HOLD_LEN    = 300;
    localparam int            CYCLE_LIMIT = 400000;
    localparam int            DRAIN_WAIT  = 40;
    localparam logic [7:0]    CH_LOW_S    = 8'h73;
    localparam logic [7:0]    CH_A        = 8'h41;
    localparam logic [7:0]    CH_FIVE     = 8'h35;
    localparam logic [7:0]    CH_MAX      = 8'hFF;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_fmt_byte;

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    logic [fsnf_pkg::IN_DATA_W-1:0] i_s_tdata  = '0;   // fmt_char[7:0], arg_value[39:8]
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    logic [fsnf_pkg::CHAR_W-1:0]    o_m_tdata;         // out_char[7:0]
    logic                           o_m_tlast;

    logic [fsnf_pkg::IN_DATA_W-1:0] pending_items[$];
    t_fmt_byte                      expected_bytes[$];
    int                             queued_count  = 0;
    int                             err_cnt       = 0;
    int                             send_idle_pct = 0;
    int                             recv_idle_pct = 0;
    bit                             hold_go       = 1'b0;
    int                             hold_cycles   = 0;
    int                             cycle_cnt     = 0;

    // formatter state as the bench sees it
    bit                             spec_open   = 1'b0;
    logic [3:0]                     field_width = fsnf_pkg::WIDTH_RESET;
    bit                             pad_zero    = 1'b0;

    format_string_number_formatter_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always #10 i_clk = ~i_clk;

    task automatic predict_format_output(input logic [7:0] c, input logic [31:0] arg);
        logic [63:0] v;
        logic [63:0] p;
        logic [3:0]  d;
        logic [7:0]  chars[$];
        bit          started;
        t_fmt_byte   e;
        v = {32'b0, arg};
        if (c == fsnf_pkg::CH_NUL) begin
            spec_open   = 1'b0;
            field_width = fsnf_pkg::WIDTH_RESET;
            pad_zero    = 1'b0;
            chars.push_back(fsnf_pkg::CH_NUL);
        end else if (!spec_open) begin
            if (c == fsnf_pkg::CH_PERCENT) spec_open = 1'b1;
            else chars.push_back(c);
        end else if (c == fsnf_pkg::CH_ZERO) begin
            pad_zero = 1'b1;
        end else if (c >= fsnf_pkg::CH_ONE && c <= fsnf_pkg::CH_NINE) begin
            field_width = 4'(c - fsnf_pkg::ASCII_ZERO);
        end else begin
            if (c == fsnf_pkg::CH_LOW_C) begin
                chars.push_back(arg[7:0]);
            end else if (c == fsnf_pkg::CH_LOW_X || c == fsnf_pkg::CH_UP_X ||
                         c == fsnf_pkg::CH_LOW_D) begin
                started = pad_zero;
                for (int i = field_width; i > 0; i--) begin
                    if (c == fsnf_pkg::CH_LOW_D) begin
                        p = 64'd1;
                        for (int j = 0; j + 1 < i; j++) p = p * 64'd10;
                        d = 4'((v / p) % 64'd10);
                    end else begin
                        // positions past bit 31 read as zero
                        d = v[(i-1)*4 +: 4];
                    end
                    if (d != 0 || started || i == 1) begin
                        chars.push_back(d < 10 ? fsnf_pkg::ASCII_ZERO + 8'(d)
                                               : fsnf_pkg::ASCII_ALPHA_OFS + 8'(d));
                        started = 1'b1;
                    end
                end
            end
            spec_open = 1'b0;
            pad_zero  = 1'b0;
        end
        foreach (chars[k]) begin
            e.ch   = chars[k];
            e.last = (k == chars.size() - 1);
            expected_bytes.push_back(e);
        end
    endtask

    task automatic queue_item(input logic [7:0] c, input logic [31:0] arg);
        pending_items.push_back({arg, c});
        queued_count++;
    endtask

    task automatic queue_conversion();
        logic [7:0] spec;
        int         k;
        queue_item(fsnf_pkg::CH_PERCENT, $urandom);
        if ($urandom_range(0, 3) == 0) queue_item(fsnf_pkg::CH_ZERO, $urandom);
        if ($urandom_range(0, 2) != 0)
            queue_item(fsnf_pkg::CH_ONE + 8'($urandom_range(0, 8)), $urandom);
        k = $urandom_range(0, 19);
        if (k < 6)       spec = fsnf_pkg::CH_LOW_D;
        else if (k < 10) spec = fsnf_pkg::CH_LOW_X;
        else if (k < 14) spec = fsnf_pkg::CH_UP_X;
        else if (k < 17) spec = fsnf_pkg::CH_LOW_C;
        else if (k < 18) spec = fsnf_pkg::CH_PERCENT;
        else if (k < 19) spec = CH_LOW_S;
        else             spec = 8'($urandom_range(0, 255));
        // shift down so short values exercise leading zero suppression
        queue_item(spec, $urandom >> $urandom_range(0, 31));
    endtask

    task automatic queue_format_string();
        logic [7:0] c;
        int         r;
        repeat ($urandom_range(1, 6)) begin
            r = $urandom_range(0, 9);
            if (r < 4) begin
                repeat ($urandom_range(1, 4)) begin
                    c = 8'($urandom_range(1, 255));
                    if (c == fsnf_pkg::CH_PERCENT) c = fsnf_pkg::CH_PERCENT + 8'd1;
                    queue_item(c, $urandom);
                end
            end else if (r < 9) begin
                queue_conversion();
            end else begin
                queue_item(8'($urandom_range(0, 255)), $urandom);
            end
        end
        if ($urandom_range(0, 99) < 85) queue_item(fsnf_pkg::CH_NUL, $urandom);
    endtask

    task automatic queue_directed();
        queue_item(CH_A, 32'h0);
        queue_item(CH_MAX, 32'hFFFF_FFFF);
        queue_item(fsnf_pkg::CH_PERCENT, 32'h0);
        queue_item(fsnf_pkg::CH_LOW_D, 32'h0);
        // zero fill, width nine: top hex position is beyond the value
        queue_item(fsnf_pkg::CH_PERCENT, 32'h0);
        queue_item(fsnf_pkg::CH_ZERO, 32'h0);
        queue_item(fsnf_pkg::CH_NINE, 32'h0);
        queue_item(fsnf_pkg::CH_LOW_X, 32'hFFFF_FFFF);
        queue_item(fsnf_pkg::CH_PERCENT, 32'h0);
        queue_item(fsnf_pkg::CH_UP_X, 32'h9ABC_DEF0);
        queue_item(fsnf_pkg::CH_PERCENT, 32'h0);
        queue_item(fsnf_pkg::CH_NINE, 32'h0);
        queue_item(fsnf_pkg::CH_LOW_D, 32'hFFFF_FFFF);
        queue_item(fsnf_pkg::CH_PERCENT, 32'h0);
        queue_item(fsnf_pkg::CH_LOW_C, 32'h1234_5641);
        queue_item(fsnf_pkg::CH_PERCENT, 32'h0);
        queue_item(fsnf_pkg::CH_PERCENT, 32'h0);
        queue_item(fsnf_pkg::CH_PERCENT, 32'h0);
        queue_item(CH_LOW_S, 32'h0);
        // terminator while a conversion is open
        queue_item(fsnf_pkg::CH_PERCENT, 32'h0);
        queue_item(CH_FIVE, 32'h0);
        queue_item(fsnf_pkg::CH_NUL, 32'h0);
        queue_item(fsnf_pkg::CH_PERCENT, 32'h0);
        queue_item(fsnf_pkg::CH_LOW_X, 32'h0000_00A9);
        queue_item(fsnf_pkg::CH_NUL, 32'hFFFF_FFFF);
    endtask

    // driver: offer the next pending byte when the slot is free
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_s_tdata  <= pending_items.pop_front();
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: one long hold-off when requested, random stalls otherwise
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_go && hold_cycles < HOLD_LEN) begin
            hold_cycles <= hold_cycles + 1;
            i_m_tready  <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor: predict on each input transaction, check each output transaction
    always @(posedge i_clk) begin
        t_fmt_byte e;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                predict_format_output(i_s_tdata[7:0], i_s_tdata[39:8]);
            if (o_m_tvalid && i_m_tready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: output byte expected none actual 0x%02h last %0b",
                             $time, o_m_tdata, o_m_tlast);
                    err_cnt++;
                end else begin
                    e = expected_bytes.pop_front();
                    if (o_m_tdata !== e.ch) begin
                        $display("%0t: out_char expected 0x%02h actual 0x%02h",
                                 $time, e.ch, o_m_tdata);
                        err_cnt++;
                    end
                    if (o_m_tlast !== e.last) begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, e.last, o_m_tlast);
                        err_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 3; ph++) begin
            @(negedge i_clk);
            case (ph)
                0: begin
                    send_idle_pct = 12;
                    recv_idle_pct = 78;
                    queue_directed();
                end
                1: begin
                    send_idle_pct = 78;
                    recv_idle_pct = 12;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_go       = 1'b1;
                end
            endcase
            while (queued_count < 25 + 110 * (ph + 1)) queue_format_string();
            while (pending_items.size() != 0 || i_s_tvalid) @(negedge i_clk);
            // hold the sender until all output of this phase has drained
            while (expected_bytes.size() != 0) @(negedge i_clk);
        end
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (err_cnt == 0 && expected_bytes.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
